// File: rtl/rtad_pkg.sv
// ----------------------------------------------------------------------------
// rtad_pkg
// Shared types, constants, the digit-to-character function and the radix
// clamp function for the radix to ASCII digit converter.
// ----------------------------------------------------------------------------
package rtad_pkg;

   localparam int VALUE_BITS_DEFAULT = 63;
   localparam int RADIX_W            = 6;
   localparam int CHAR_W             = 7;

   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

   localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(48);
   localparam logic [CHAR_W-1:0]  CHAR_A      = CHAR_W'(65);
   localparam logic [RADIX_W-1:0] DECIMAL_TOP = RADIX_W'(10);

   typedef struct packed {
      logic load;
      logic step;
      logic push;
      logic read;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic step_last;
      logic quot_zero;
      logic last_digit;
   } status_type;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DECIMAL_TOP) begin
         c = CHAR_ZERO + CHAR_W'(d);
      end else begin
         c = CHAR_A + CHAR_W'(d - DECIMAL_TOP);
      end
      return c;
   endfunction

   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] b;
      if (r < RADIX_MIN) begin
         b = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         b = RADIX_MAX;
      end else begin
         b = r;
      end
      return b;
   endfunction

endpackage

// File: rtl/rtad_ctrl.sv
// ----------------------------------------------------------------------------
// rtad_ctrl
// Sequencer: runs one bit-serial division per digit, pushes digits onto the
// digit stack, then pops them out most significant first.
// ----------------------------------------------------------------------------
module rtad_ctrl
   import rtad_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_STORE,
      ST_READ,
      ST_SHOW
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (status.step_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.push = 1'b1;
            state_in = status.quot_zero ? ST_READ : ST_DIVIDE;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_ready) begin
               cmd.pop  = 1'b1;
               state_in = status.last_digit ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_SHOW);

endmodule

// File: rtl/rtad_datapath.sv
// ----------------------------------------------------------------------------
// rtad_datapath
// Radix register, restoring bit-serial divider, digit stack memory and the
// registered result.
// ----------------------------------------------------------------------------
module rtad_datapath
   import rtad_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [RADIX_W-1:0]    csr_radix,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic [CHAR_W-1:0]     rsp_digit_char,
   output logic                  rsp_last_digit,
   input  cmd_type               cmd,
   output status_type            status
);

   localparam int ADDR_W = $clog2(VALUE_BITS);
   localparam int CNT_W  = $clog2(VALUE_BITS + 1);
   localparam logic [ADDR_W-1:0] STEP_TOP = ADDR_W'(VALUE_BITS - 1);

   logic [RADIX_W-1:0]    base_ff;
   logic [VALUE_BITS-1:0] quot_ff;
   logic [RADIX_W-1:0]    rem_ff;
   logic [ADDR_W-1:0]     step_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CHAR_W-1:0]     char_ff;
   logic                  last_ff;
   logic [CHAR_W-1:0]     stack_mem [VALUE_BITS];

   logic [RADIX_W:0]      trial;
   logic                  fits;
   logic [RADIX_W:0]      diff;
   logic [RADIX_W-1:0]    rem_in;
   logic [CNT_W-1:0]      cnt_dec;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= RADIX_RESET;
      end else if (csr_valid) begin
         base_ff <= clamp_radix(csr_radix);
      end
   end

   // one quotient bit per cycle
   assign trial   = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign fits    = trial >= {1'b0, base_ff};
   assign diff    = trial - {1'b0, base_ff};
   assign rem_in  = fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
   assign cnt_dec = cnt_ff - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         quot_ff <= req_value;
         rem_ff  <= '0;
         step_ff <= STEP_TOP;
      end else if (cmd.step) begin
         quot_ff <= {quot_ff[VALUE_BITS-2:0], fits};
         rem_ff  <= rem_in;
         step_ff <= step_ff - ADDR_W'(1);
      end else if (cmd.push) begin
         rem_ff  <= '0;
         step_ff <= STEP_TOP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.load) begin
         cnt_ff <= '0;
      end else if (cmd.push) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         cnt_ff <= cnt_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[cnt_ff[ADDR_W-1:0]] <= digit_to_ascii(rem_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         char_ff <= stack_mem[cnt_dec[ADDR_W-1:0]];
         last_ff <= (cnt_ff == CNT_W'(1));
      end
   end

   assign rsp_digit_char    = char_ff;
   assign rsp_last_digit    = last_ff;
   assign status.step_last  = (step_ff == '0);
   assign status.quot_zero  = (quot_ff == '0);
   assign status.last_digit = last_ff;

endmodule

// File: rtl/radix_to_ascii_digits_unit.sv
// ----------------------------------------------------------------------------
// radix_to_ascii_digits_unit
// Converts an unsigned integer into ASCII digits of a programmable base,
// most significant digit first, flagging the final digit.
// ----------------------------------------------------------------------------
//  channel   ports                                   direction
//  req       req_valid/req_ready, req_value          in
//  rsp       rsp_valid/rsp_ready, rsp_digit_char,    out
//            rsp_last_digit
//  csr       csr_valid/csr_ready, csr_radix          in
//
//  Each digit is found by a bit-serial division over all VALUE_BITS bits of
//  the quotient, then pushed onto the digit stack; each digit out is read
//  from the stack, then held on rsp until rsp_ready takes it. One item at a
//  time; req_ready is high only when idle. Synchronous reset sets radix to 10.
// ----------------------------------------------------------------------------
module radix_to_ascii_digits_unit
   import rtad_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [RADIX_W-1:0]    csr_radix,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHAR_W-1:0]     rsp_digit_char,
   output logic                  rsp_last_digit
);

   cmd_type    cmd;
   status_type status;

   rtad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rtad_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_radix      (csr_radix),
      .req_value      (req_value),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit),
      .cmd            (cmd),
      .status         (status)
   );

endmodule
